// File: src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants for the lru key-value cache
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } op_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // input beat accepted
    logic match;   // compare stage
    logic update;  // store update and result capture
  } lkvc_cmd_t;

endpackage

`default_nettype wire

// File: src/lkvc_ctrl.sv
// ----------------------------------------------------------------------------
// lkvc_ctrl
// sequencer: accept, match, update; owns the result valid flag
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lkvc_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   finish;
  logic   accept;

  assign slot_free = !out_valid_q || out_ready_i;
  assign finish    = (state_q == S_UPDATE) && slot_free;
  assign in_ready_o = (state_q == S_IDLE) || finish;
  assign accept    = in_valid_i && in_ready_o;

  assign cmd_o.load   = accept;
  assign cmd_o.match  = (state_q == S_MATCH);
  assign cmd_o.update = finish;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MATCH;
      end
      S_MATCH: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (finish) state_d = accept ? S_MATCH : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    priority if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: src/lkvc_dp.sv
// ----------------------------------------------------------------------------
// lkvc_dp
// key cam, value memory, recency ranks, occupancy and result registers
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lkvc_cmd_t             cmd_i,
  input  wire logic                  operation_i,
  input  wire logic [KEY_BITS-1:0]   lookup_key_i,
  input  wire logic [VALUE_BITS-1:0] write_value_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CAP_W-1:0]      cfg_wdata_i,
  output logic                       hit_o,
  output logic [VALUE_BITS-1:0]      read_value_o,
  output logic                       evicted_o
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // store
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_BITS-1:0] mem     [ENTRIES];
  logic [IDX_W-1:0]      rank_q  [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  logic [OCC_W-1:0]      occ_q;
  logic [CAP_W-1:0]      capacity_q;

  // latched item
  op_e                   op_q;
  logic [KEY_BITS-1:0]   in_key_q;
  logic [VALUE_BITS-1:0] in_value_q;

  // match stage results
  logic                  active_q;
  logic                  hit_q;
  logic [IDX_W-1:0]      hit_idx_q;
  logic [IDX_W-1:0]      hit_rank_q;
  logic [ENTRIES-1:0]    evict_q;
  logic                  free_ok_q;
  logic [IDX_W-1:0]      free_idx_q;

  // result registers
  logic                  res_hit_q;
  logic                  res_ev_q;
  logic                  res_show_q;
  logic [VALUE_BITS-1:0] rdata_q;

  // match stage logic
  logic [ENTRIES-1:0]    match_vec;
  logic [ENTRIES-1:0]    evict_vec;
  logic [ENTRIES-1:0]    valid_after;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      hit_rank;
  logic [IDX_W-1:0]      lru_rank;
  logic [IDX_W-1:0]      free_idx;
  logic                  free_ok;
  logic [CMP_W-1:0]      cap_eff;
  logic                  full;
  logic                  cap_zero;
  logic                  miss_write;

  // update stage logic
  logic                  ev_any;
  logic                  insert;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;

  assign cap_zero = (capacity_q == '0);
  assign cap_eff  = (CMP_W'(capacity_q) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                            : CMP_W'(capacity_q);
  assign full     = (CMP_W'(occ_q) >= cap_eff);
  // ranks of valid entries form 0..occ-1, so the least recent holds occ-1
  assign lru_rank = IDX_W'(occ_q - OCC_W'(1));

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_q[i] && (key_q[i] == in_key_q);
      // keys are unique among valid entries, so an or-mux is enough
      if (match_vec[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_q[i];
      end
    end
  end

  assign miss_write = (op_q == OP_WRITE) && !(|match_vec);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      evict_vec[i] = miss_write && full && valid_q[i] && (rank_q[i] == lru_rank);
    end
    valid_after = valid_q & ~evict_vec;
    free_ok  = 1'b0;
    free_idx = '0;
    // lowest free slot wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after[i]) begin
        free_ok  = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign ev_any = |evict_q;
  assign insert = active_q && (op_q == OP_WRITE) && !hit_q && free_ok_q;

  // input latch, match stage and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= op_e'(operation_i);
      in_key_q   <= lookup_key_i;
      in_value_q <= write_value_i;
    end
    if (cmd_i.match) begin
      active_q   <= !cap_zero;
      hit_q      <= |match_vec;
      hit_idx_q  <= hit_idx;
      hit_rank_q <= hit_rank;
      evict_q    <= evict_vec;
      free_ok_q  <= free_ok;
      free_idx_q <= free_idx;
    end
    if (cmd_i.update) begin
      res_hit_q  <= active_q && hit_q;
      res_ev_q   <= active_q && (op_q == OP_WRITE) && !hit_q && ev_any;
      res_show_q <= active_q && hit_q && (op_q == OP_LOOKUP);
    end
  end

  // value memory: one write and one registered read port
  assign mem_we    = cmd_i.update && active_q && (op_q == OP_WRITE) && (hit_q || free_ok_q);
  assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_value_q;
    end
    if (cmd_i.update && active_q && hit_q && (op_q == OP_LOOKUP)) begin
      rdata_q <= mem[hit_idx_q];
    end
  end

  // key cam contents
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && insert) begin
      key_q[free_idx_q] <= in_key_q;
    end
  end

  // valid bits, ranks and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.update && active_q) begin
      if (hit_q) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == hit_idx_q) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank_q)) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
      end else if (op_q == OP_WRITE) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (free_ok_q && (IDX_W'(i) == free_idx_q)) begin
            valid_q[i] <= 1'b1;
            rank_q[i]  <= '0;
          end else if (evict_q[i]) begin
            valid_q[i] <= 1'b0;
            rank_q[i]  <= '0;
          end else if (valid_q[i] && free_ok_q) begin
            rank_q[i] <= rank_q[i] + IDX_W'(1);
          end
        end
        if (ev_any && !insert) begin
          occ_q <= occ_q - OCC_W'(1);
        end else if (!ev_any && insert) begin
          occ_q <= occ_q + OCC_W'(1);
        end
      end
    end
  end

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  assign hit_o        = res_hit_q;
  assign evicted_o    = res_ev_q;
  assign read_value_o = res_show_q ? rdata_q : '0;

endmodule

`default_nettype wire

// File: src/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o| operation_i, lookup_key_i, write_value_i
//   out      | out_valid_o/out_ready_i| hit_o, read_value_o, evicted_o
//   cfg      | cfg_we_i               | cfg_wdata_i (capacity)
//
// an item first compares its key against every entry, then does the
// recency update and write-back; a new beat is accepted in the update cycle
// reset clears valid bits, ranks and occupancy at once, no clearing pass
// the result waits in an output register; a stalled output holds the next
// item in its update cycle until the result register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  operation_i,
  input  wire logic [KEY_BITS-1:0]   lookup_key_i,
  input  wire logic [VALUE_BITS-1:0] write_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       hit_o,
  output logic [VALUE_BITS-1:0]      read_value_o,
  output logic                       evicted_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CAP_W-1:0]      cfg_wdata_i
);

  lkvc_cmd_t cmd;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  lkvc_dp #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .evicted_o     (evicted_o)
  );

endmodule

`default_nettype wire
